>>> hw/rtl/wpp_pkg.sv
// ----------------------------------------------------------------------------
// wpp_pkg
// Shared types and codes for the WAV PCM16 mono parser.
// ----------------------------------------------------------------------------
`default_nettype none

package wpp_pkg;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_NOT_WAV     = 3'd1;
    localparam logic [2:0] ST_SHORT_FMT   = 3'd2;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd3;
    localparam logic [2:0] ST_WRONG_RATE  = 3'd4;
    localparam logic [2:0] ST_NO_SAMPLES  = 3'd5;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       end_of_file;
    } in_item_t;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] sample;
        logic               chunk_first;
        logic [2:0]         status;
        logic               last;
    } out_item_t;

    // One queue entry: everything a single input byte produces.
    typedef struct packed {
        logic               smp_valid;
        logic signed [15:0] sample;
        logic               chunk_first;
        logic               rpt_valid;
        logic [2:0]         status;
    } q_entry_t;

endpackage

`default_nettype wire

>>> hw/rtl/wpp_front.sv
// ----------------------------------------------------------------------------
// wpp_front
// Byte parser: RIFF/WAVE header check, chunk walk, fmt checks, sample pairing.
// ----------------------------------------------------------------------------
`default_nettype none

module wpp_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [31:0]       cfg_wr_data,
    input  wire logic              in_valid,
    input  wire wpp_pkg::in_item_t in_data,
    output logic                   in_stall,
    input  wire logic              q_full,
    output logic                   push,
    output wpp_pkg::q_entry_t      push_entry
);

    typedef enum logic [6:0] {
        PH_RIFF  = 7'b0000001,
        PH_HDR   = 7'b0000010,
        PH_FMT   = 7'b0000100,
        PH_DATA  = 7'b0001000,
        PH_SKIP  = 7'b0010000,
        PH_PAD   = 7'b0100000,
        PH_DRAIN = 7'b1000000
    } phase_t;

    localparam logic [31:0] TAG_RIFF    = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE    = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT     = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA    = 32'h6461_7461;
    localparam logic [31:0] FMT_MIN_LEN = 32'd16;
    localparam logic [31:0] RATE_RESET  = 32'd16000;
    localparam logic [15:0] FMT_PCM     = 16'd1;
    localparam logic [15:0] CHAN_MONO   = 16'd1;
    localparam logic [15:0] BITS_16     = 16'd16;

    phase_t      phase_reg, phase_next;
    logic [31:0] cnt_reg, cnt_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] tag_reg, tag_next;
    logic [55:0] fmt_reg, fmt_next;
    logic [31:0] rate_reg, rate_next;
    logic [7:0]  hold_reg, hold_next;
    logic        have_reg, have_next;
    logic        firstp_reg, firstp_next;
    logic [31:0] req_rate_reg;

    logic        accept;
    logic [7:0]  b;
    logic [31:0] cnt_inc;
    logic        err_v;
    logic [2:0]  err_code;
    logic        smp_v;
    logic        rpt_v;
    logic [2:0]  rpt_status;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign b        = in_data.file_byte;
    assign cnt_inc  = cnt_reg + 32'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        len_next    = len_reg;
        tag_next    = tag_reg;
        fmt_next    = fmt_reg;
        rate_next   = rate_reg;
        hold_next   = hold_reg;
        have_next   = have_reg;
        firstp_next = firstp_reg;
        err_v       = 1'b0;
        err_code    = wpp_pkg::ST_OK;
        smp_v       = 1'b0;
        rpt_v       = 1'b0;
        rpt_status  = wpp_pkg::ST_OK;

        unique case (phase_reg)
            PH_RIFF:
            begin
                tag_next = {tag_reg[23:0], b};
                cnt_next = cnt_inc;
                if (cnt_inc == 32'd4 && tag_next != TAG_RIFF)
                begin
                    err_v    = 1'b1;
                    err_code = wpp_pkg::ST_NOT_WAV;
                end
                else if (cnt_inc == 32'd12)
                begin
                    if (tag_next != TAG_WAVE)
                    begin
                        err_v    = 1'b1;
                        err_code = wpp_pkg::ST_NOT_WAV;
                    end
                    else
                    begin
                        phase_next = PH_HDR;
                        cnt_next   = 32'd0;
                    end
                end
            end
            PH_HDR:
            begin
                if (cnt_reg == 32'd0)
                    len_next = 32'd0;
                if (cnt_reg < 32'd4)
                    tag_next = {tag_reg[23:0], b};
                else
                    len_next[8*cnt_reg[1:0] +: 8] = b;
                cnt_next = cnt_inc;
                if (cnt_inc == 32'd8)
                begin
                    if (tag_next == TAG_FMT && len_next < FMT_MIN_LEN)
                    begin
                        err_v    = 1'b1;
                        err_code = wpp_pkg::ST_SHORT_FMT;
                    end
                    else
                    begin
                        cnt_next = 32'd0;
                        if (tag_next == TAG_DATA)
                        begin
                            have_next   = 1'b0;
                            firstp_next = 1'b1;
                        end
                        if (len_next == 32'd0)
                            phase_next = PH_HDR;
                        else if (tag_next == TAG_FMT)
                            phase_next = PH_FMT;
                        else if (tag_next == TAG_DATA)
                            phase_next = PH_DATA;
                        else
                            phase_next = PH_SKIP;
                    end
                end
            end
            PH_FMT:
            begin
                if (cnt_reg < 32'd7)
                    fmt_next = {b, fmt_reg[55:8]};
                if (cnt_reg == 32'd7)
                begin
                    rate_next = {b, fmt_reg[55:32]};
                    if (fmt_reg[15:0] != FMT_PCM || fmt_reg[31:16] != CHAN_MONO)
                    begin
                        err_v    = 1'b1;
                        err_code = wpp_pkg::ST_UNSUPPORTED;
                    end
                end
                else if (cnt_reg == 32'd14)
                    hold_next = b;
                else if (cnt_reg == 32'd15 && {b, hold_reg} != BITS_16)
                begin
                    err_v    = 1'b1;
                    err_code = wpp_pkg::ST_UNSUPPORTED;
                end
                cnt_next = cnt_inc;
                if (!err_v && cnt_inc == len_reg)
                begin
                    cnt_next   = 32'd0;
                    phase_next = len_reg[0] ? PH_PAD : PH_HDR;
                end
            end
            PH_DATA:
            begin
                if (!cnt_reg[0])
                    hold_next = b;
                else
                begin
                    smp_v       = 1'b1;
                    firstp_next = 1'b0;
                    have_next   = 1'b1;
                end
                cnt_next = cnt_inc;
                if (cnt_inc == len_reg)
                begin
                    cnt_next   = 32'd0;
                    phase_next = len_reg[0] ? PH_PAD : PH_HDR;
                end
            end
            PH_SKIP:
            begin
                cnt_next = cnt_inc;
                if (cnt_inc == len_reg)
                begin
                    cnt_next   = 32'd0;
                    phase_next = len_reg[0] ? PH_PAD : PH_HDR;
                end
            end
            PH_PAD:
            begin
                phase_next = PH_HDR;
                cnt_next   = 32'd0;
            end
            PH_DRAIN:
                phase_next = PH_DRAIN;
            default:
                phase_next = PH_DRAIN;
        endcase

        if (err_v)
        begin
            rpt_v      = 1'b1;
            rpt_status = err_code;
            phase_next = PH_DRAIN;
        end

        if (in_data.end_of_file)
        begin
            if (!err_v && phase_reg != PH_DRAIN)
            begin
                rpt_v = 1'b1;
                if (phase_next == PH_RIFF)
                    rpt_status = wpp_pkg::ST_NOT_WAV;
                else if (phase_next == PH_FMT && cnt_next < FMT_MIN_LEN)
                    rpt_status = wpp_pkg::ST_UNSUPPORTED;
                else if (rate_next != req_rate_reg)
                    rpt_status = wpp_pkg::ST_WRONG_RATE;
                else if (!have_next)
                    rpt_status = wpp_pkg::ST_NO_SAMPLES;
                else
                    rpt_status = wpp_pkg::ST_OK;
            end
            phase_next  = PH_RIFF;
            cnt_next    = 32'd0;
            rate_next   = 32'd0;
            have_next   = 1'b0;
            firstp_next = 1'b0;
        end
    end

    assign push                   = accept && (smp_v || rpt_v);
    assign push_entry.smp_valid   = smp_v;
    assign push_entry.sample      = {b, hold_reg};
    assign push_entry.chunk_first = firstp_reg;
    assign push_entry.rpt_valid   = rpt_v;
    assign push_entry.status      = rpt_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_RIFF;
            cnt_reg      <= 32'd0;
            len_reg      <= 32'd0;
            rate_reg     <= 32'd0;
            have_reg     <= 1'b0;
            firstp_reg   <= 1'b0;
            req_rate_reg <= RATE_RESET;
        end
        else
        begin
            if (cfg_wr_en)
                req_rate_reg <= cfg_wr_data;
            if (accept)
            begin
                phase_reg  <= phase_next;
                cnt_reg    <= cnt_next;
                len_reg    <= len_next;
                rate_reg   <= rate_next;
                have_reg   <= have_next;
                firstp_reg <= firstp_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tag_reg  <= tag_next;
            fmt_reg  <= fmt_next;
            hold_reg <= hold_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/wpp_queue.sv
// ----------------------------------------------------------------------------
// wpp_queue
// Small FIFO of parser results between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module wpp_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire wpp_pkg::q_entry_t push_entry,
    input  wire logic              pop,
    output logic                   full,
    output logic                   head_valid,
    output wpp_pkg::q_entry_t      head_entry
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

    wpp_pkg::q_entry_t mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] cnt_reg;
    logic          do_push, do_pop;

    assign full       = (cnt_reg == DEPTH_CNT);
    assign head_valid = (cnt_reg != '0);
    assign head_entry = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + AW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + AW'(1);
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + CW'(1);
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - CW'(1);
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/wpp_back.sv
// ----------------------------------------------------------------------------
// wpp_back
// Result sequencer: splits queue entries into sample and report results and
// holds them in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wpp_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              head_valid,
    input  wire wpp_pkg::q_entry_t head_entry,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output wpp_pkg::out_item_t     out_data
);

    logic               out_valid_reg, out_valid_next;
    wpp_pkg::out_item_t out_reg, out_next;
    logic               rpt_pend_reg, rpt_pend_next;
    logic               load_ok;
    wpp_pkg::out_item_t smp_item, rpt_item;

    always_comb
    begin
        smp_item.kind        = wpp_pkg::KIND_SAMPLE;
        smp_item.sample      = head_entry.sample;
        smp_item.chunk_first = head_entry.chunk_first;
        smp_item.status      = wpp_pkg::ST_OK;
        smp_item.last        = 1'b0;

        rpt_item.kind        = wpp_pkg::KIND_REPORT;
        rpt_item.sample      = '0;
        rpt_item.chunk_first = 1'b0;
        rpt_item.status      = head_entry.status;
        rpt_item.last        = 1'b1;
    end

    assign load_ok = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        rpt_pend_next  = rpt_pend_reg;
        pop            = 1'b0;
        if (load_ok)
        begin
            out_valid_next = head_valid;
            if (head_valid)
            begin
                if (rpt_pend_reg || !head_entry.smp_valid)
                begin
                    out_next      = rpt_item;
                    rpt_pend_next = 1'b0;
                    pop           = 1'b1;
                end
                else
                begin
                    out_next      = smp_item;
                    rpt_pend_next = head_entry.rpt_valid;
                    pop           = !head_entry.rpt_valid;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            rpt_pend_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            rpt_pend_reg  <= rpt_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

>>> hw/rtl/wav_pcm16_mono_parser_core.sv
// ----------------------------------------------------------------------------
// wav_pcm16_mono_parser_core
// WAV file parser for 16-bit mono PCM, one file byte per request.
//
// Input channel in_valid/in_stall/in_data carries file_byte and end_of_file.
// Output channel out_valid/out_stall/out_data carries samples (kind 0, Q1.15,
// chunk_first on the first sample of each data chunk) and one status report
// (kind 1, last 1) that closes each file.
// cfg_wr_en/cfg_wr_data write the required sample rate; write it only while
// the block is idle.
// Throughput: one byte per cycle while in_stall is low. A byte that completes
// a sample and also ends the file yields a sample result and then its report.
// Path: a result is written into the result queue on the edge that accepts
// its byte, and loads into the output register once it reaches the queue head
// and the output register is free.
// in_stall rises when the result queue is full; a stalled output holds.
// Reset: required rate 16000 Hz, parser at the RIFF header, queue empty.
// ----------------------------------------------------------------------------
`default_nettype none

module wav_pcm16_mono_parser_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [31:0]       cfg_wr_data,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire wpp_pkg::in_item_t in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output wpp_pkg::out_item_t     out_data
);

    logic              q_full;
    logic              push;
    wpp_pkg::q_entry_t push_entry;
    logic              pop;
    logic              head_valid;
    wpp_pkg::q_entry_t head_entry;

    wpp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_data     (in_data),
        .in_stall    (in_stall),
        .q_full      (q_full),
        .push        (push),
        .push_entry  (push_entry)
    );

    wpp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    wpp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

`default_nettype wire

>>> hw/rtl/wpp_checker.sv
// ----------------------------------------------------------------------------
// wpp_checker
// Port-level checks on the parser's output results.
// ----------------------------------------------------------------------------
`default_nettype none

module wpp_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire wpp_pkg::out_item_t out_data
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output changed while stalled");

    a_report_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == wpp_pkg::KIND_REPORT |-> out_data.last)
        else $error("report without last");

    a_sample_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == wpp_pkg::KIND_SAMPLE
        |-> !out_data.last && out_data.status == wpp_pkg::ST_OK)
        else $error("sample carries report fields");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == wpp_pkg::KIND_REPORT
        |-> out_data.status <= wpp_pkg::ST_NO_SAMPLES)
        else $error("status code out of range");

endmodule

bind wav_pcm16_mono_parser_core wpp_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire

>>> sim/wav_pcm16_mono_parser_core_test.sv
// ----------------------------------------------------------------------------
// wav_pcm16_mono_parser_core_test
// Self-checking bench for the WAV PCM16 mono parser. A short table of header
// requests comes first, then generated WAV files: good ones, broken fmt
// chunks, wrong rates, empty and truncated data, missing chunks and noise.
// Every accepted byte goes through a local parser model, and each result from
// the block is compared with the oldest predicted one. Random valid and stall
// bursts on both channels, and the required rate is rewritten between files.
// ----------------------------------------------------------------------------
module wav_pcm16_mono_parser_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 1030;
    localparam int SEGMENTS      = 6;

    localparam logic [31:0] TAG_RIFF    = "RIFF";
    localparam logic [31:0] TAG_WAVE    = "WAVE";
    localparam logic [31:0] TAG_FMT     = "fmt ";
    localparam logic [31:0] TAG_DATA    = "data";
    localparam logic [31:0] TAG_LIST    = "LIST";
    localparam logic [31:0] FMT_MIN_LEN = 32'd16;

    // slot 3 is replaced by a random rate
    localparam logic [31:0] RATE_PLAN[SEGMENTS] =
        '{32'd16000, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd44100, 32'd16000};

    typedef enum logic [6:0] {
        PH_RIFF      = 7'b0000001,
        PH_CHUNK_HDR = 7'b0000010,
        PH_FMT_BODY  = 7'b0000100,
        PH_DATA_BODY = 7'b0001000,
        PH_SKIP_BODY = 7'b0010000,
        PH_PAD       = 7'b0100000,
        PH_DRAINED   = 7'b1000000
    } parse_phase_t;

    typedef enum int {
        FK_GOOD,
        FK_SHORT_FMT,
        FK_BAD_CODE,
        FK_BAD_CHANS,
        FK_BAD_BITS,
        FK_WRONG_RATE,
        FK_NO_SAMPLES,
        FK_NO_FMT,
        FK_CUT,
        FK_LONG_DATA,
        FK_BAD_WAVE,
        FK_NOISE
    } file_kind_t;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       end_of_file;
        logic       typed;
        logic [2:0] status;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 23;
    localparam directed_row_t DIRECTED[DIRECTED_ROWS] = '{
        // bad RIFF tag right after reset, then the end of file is swallowed
        '{"R", 1'b0, 1'b0, wpp_pkg::ST_OK},
        '{"I", 1'b0, 1'b0, wpp_pkg::ST_OK},
        '{"F", 1'b0, 1'b0, wpp_pkg::ST_OK},
        '{"X", 1'b0, 1'b1, wpp_pkg::ST_NOT_WAV},
        '{8'hFF, 1'b1, 1'b0, wpp_pkg::ST_OK},
        // one-byte file
        '{8'h00, 1'b1, 1'b1, wpp_pkg::ST_NOT_WAV},
        // bad WAVE tag
        '{"R", 1'b0, 1'b0, wpp_pkg::ST_OK},
        '{"I", 1'b0, 1'b0, wpp_pkg::ST_OK},
        '{"F", 1'b0, 1'b0, wpp_pkg::ST_OK},
        '{"F", 1'b0, 1'b0, wpp_pkg::ST_OK},
        '{8'h00, 1'b0, 1'b0, wpp_pkg::ST_OK},
        '{8'hFF, 1'b0, 1'b0, wpp_pkg::ST_OK},
        '{8'h80, 1'b0, 1'b0, wpp_pkg::ST_OK},
        '{8'h7F, 1'b0, 1'b0, wpp_pkg::ST_OK},
        '{"W", 1'b0, 1'b0, wpp_pkg::ST_OK},
        '{"A", 1'b0, 1'b0, wpp_pkg::ST_OK},
        '{"V", 1'b0, 1'b0, wpp_pkg::ST_OK},
        '{"X", 1'b0, 1'b1, wpp_pkg::ST_NOT_WAV},
        '{8'h00, 1'b1, 1'b0, wpp_pkg::ST_OK},
        // RIFF header cut short after a good tag
        '{"R", 1'b0, 1'b0, wpp_pkg::ST_OK},
        '{"I", 1'b0, 1'b0, wpp_pkg::ST_OK},
        '{"F", 1'b0, 1'b0, wpp_pkg::ST_OK},
        '{"F", 1'b1, 1'b1, wpp_pkg::ST_NOT_WAV}
    };

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [31:0]        cfg_wr_data;
    logic               in_valid;
    logic               in_stall;
    wpp_pkg::in_item_t  in_data;
    logic               out_valid;
    logic               out_stall = 1'b0;
    wpp_pkg::out_item_t out_data;

    logic        row_typed;
    logic [2:0]  row_status;
    logic        idling_on;
    int          stall_left = 0;
    int          bytes_sent = 0;
    int          mismatches = 0;

    wpp_pkg::out_item_t pending_results[$];
    wpp_pkg::out_item_t byte_results[$];
    logic [7:0]         file_image[$];

    // parser model state
    logic [31:0]  cfg_rate;
    parse_phase_t ph;
    logic [31:0]  byte_cnt;
    logic [31:0]  chunk_len;
    logic [31:0]  tag_window;
    logic [63:0]  fmt_bytes;
    logic [31:0]  stated_rate;
    logic [7:0]   low_hold;
    logic         got_samples;
    logic         first_due;

    wav_pcm16_mono_parser_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic wpp_pkg::out_item_t status_report(input logic [2:0] st);
        return '{kind: wpp_pkg::KIND_REPORT, sample: '0, chunk_first: 1'b0,
                 status: st, last: 1'b1};
    endfunction

    function automatic void restart_file();
        ph          = PH_RIFF;
        byte_cnt    = '0;
        chunk_len   = '0;
        tag_window  = '0;
        fmt_bytes   = '0;
        stated_rate = '0;
        low_hold    = '0;
        got_samples = 1'b0;
        first_due   = 1'b0;
    endfunction

    function automatic void close_body();
        byte_cnt = '0;
        ph = chunk_len[0] ? PH_PAD : PH_CHUNK_HDR;
    endfunction

    function automatic void open_body(input parse_phase_t next_ph);
        byte_cnt = '0;
        if (chunk_len == 0)
            close_body();
        else
            ph = next_ph;
    endfunction

    function automatic void parse_byte(input logic [7:0] b, input logic eof);
        logic [2:0]         err;
        logic [2:0]         st;
        logic               was_drained;
        logic [31:0]        k;
        wpp_pkg::out_item_t smp_res;
        byte_results.delete();
        err = wpp_pkg::ST_OK;
        was_drained = (ph == PH_DRAINED);
        k = byte_cnt;
        case (ph)
            PH_RIFF:
            begin
                tag_window = {tag_window[23:0], b};
                byte_cnt = k + 1;
                if (byte_cnt == 4 && tag_window != TAG_RIFF)
                    err = wpp_pkg::ST_NOT_WAV;
                else if (byte_cnt == 12)
                begin
                    if (tag_window != TAG_WAVE)
                        err = wpp_pkg::ST_NOT_WAV;
                    else
                    begin
                        ph = PH_CHUNK_HDR;
                        byte_cnt = '0;
                    end
                end
            end
            PH_CHUNK_HDR:
            begin
                if (k == 0)
                begin
                    chunk_len = '0;
                    fmt_bytes = '0;
                end
                if (k < 4)
                    tag_window = {tag_window[23:0], b};
                else
                    chunk_len = chunk_len | ({24'd0, b} << (8 * (k - 4)));
                byte_cnt = k + 1;
                if (byte_cnt == 8)
                begin
                    if (tag_window == TAG_FMT)
                    begin
                        if (chunk_len < FMT_MIN_LEN)
                            err = wpp_pkg::ST_SHORT_FMT;
                        else
                            open_body(PH_FMT_BODY);
                    end
                    else if (tag_window == TAG_DATA)
                    begin
                        got_samples = 1'b0;
                        first_due = 1'b1;
                        open_body(PH_DATA_BODY);
                    end
                    else
                        open_body(PH_SKIP_BODY);
                end
            end
            PH_FMT_BODY:
            begin
                if (k < 8)
                    fmt_bytes[8 * k +: 8] = b;
                if (k == 7)
                begin
                    stated_rate = fmt_bytes[63:32];
                    if (fmt_bytes[15:0] != 16'd1 || fmt_bytes[31:16] != 16'd1)
                        err = wpp_pkg::ST_UNSUPPORTED;
                end
                else if (k == 14)
                    low_hold = b;
                else if (k == 15)
                begin
                    if ({b, low_hold} != 16'd16)
                        err = wpp_pkg::ST_UNSUPPORTED;
                end
                byte_cnt = k + 1;
                if (err == wpp_pkg::ST_OK && byte_cnt == chunk_len)
                    close_body();
            end
            PH_DATA_BODY:
            begin
                if (!k[0])
                    low_hold = b;
                else
                begin
                    smp_res = '{kind: wpp_pkg::KIND_SAMPLE, sample: {b, low_hold},
                                chunk_first: first_due, status: wpp_pkg::ST_OK,
                                last: 1'b0};
                    byte_results = {byte_results, smp_res};
                    first_due = 1'b0;
                    got_samples = 1'b1;
                end
                byte_cnt = k + 1;
                if (byte_cnt == chunk_len)
                    close_body();
            end
            PH_SKIP_BODY:
            begin
                byte_cnt = k + 1;
                if (byte_cnt == chunk_len)
                    close_body();
            end
            PH_PAD:
            begin
                ph = PH_CHUNK_HDR;
                byte_cnt = '0;
            end
            default:
                ph = PH_DRAINED;
        endcase

        if (err != wpp_pkg::ST_OK)
        begin
            byte_results = {byte_results, status_report(err)};
            ph = PH_DRAINED;
        end

        if (eof)
        begin
            if (err == wpp_pkg::ST_OK && !was_drained)
            begin
                if (ph == PH_RIFF)
                    st = wpp_pkg::ST_NOT_WAV;
                else if (ph == PH_FMT_BODY && byte_cnt < FMT_MIN_LEN)
                    st = wpp_pkg::ST_UNSUPPORTED;
                else if (stated_rate != cfg_rate)
                    st = wpp_pkg::ST_WRONG_RATE;
                else if (!got_samples)
                    st = wpp_pkg::ST_NO_SAMPLES;
                else
                    st = wpp_pkg::ST_OK;
                byte_results = {byte_results, status_report(st)};
            end
            restart_file();
        end
    endfunction

    function automatic void flag_field(input string name, input logic signed [31:0] want,
                                       input logic signed [31:0] got);
        mismatches++;
        $error("%s: expected %0d, actual %0d", name, want, got);
    endfunction

    always @(posedge clk)
    begin
        wpp_pkg::out_item_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                parse_byte(in_data.file_byte, in_data.end_of_file);
                if (row_typed)
                    pending_results = {pending_results, status_report(row_status)};
                else
                    pending_results = {pending_results, byte_results};
            end
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                    flag_field("unexpected result, status", -1, out_data.status);
                else
                begin
                    want = pending_results.pop_front();
                    if (out_data.kind !== want.kind)
                        flag_field("kind", want.kind, out_data.kind);
                    if (out_data.sample !== want.sample)
                        flag_field("sample", want.sample, out_data.sample);
                    if (out_data.chunk_first !== want.chunk_first)
                        flag_field("chunk_first", want.chunk_first, out_data.chunk_first);
                    if (out_data.status !== want.status)
                        flag_field("status", want.status, out_data.status);
                    if (out_data.last !== want.last)
                        flag_field("last", want.last, out_data.last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (idling_on && $urandom_range(0, 6) == 0)
        begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 7);
        end
        else
            out_stall <= 1'b0;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic eof, input logic typed,
                             input logic [2:0] st);
        if (idling_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        in_data    <= '{file_byte: b, end_of_file: eof};
        row_typed  <= typed;
        row_status <= st;
        do
            @(posedge clk);
        while (in_stall);
        bytes_sent++;
    endtask

    task automatic wait_results_done();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_required_rate(input logic [31:0] rate);
        wait_results_done();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= rate;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cfg_rate = rate;
    endtask

    function automatic void push_tag(input logic [31:0] tag);
        for (int i = 3; i >= 0; i--)
            file_image = {file_image, tag[8 * i +: 8]};
    endfunction

    function automatic void push_le(input logic [31:0] value, input int nbytes);
        for (int i = 0; i < nbytes; i++)
            file_image = {file_image, value[8 * i +: 8]};
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] other_than(input logic [15:0] v);
        logic [15:0] r;
        r = 16'($urandom);
        if (r == v)
            r = ~v;
        return r;
    endfunction

    function automatic void build_file(input file_kind_t fk);
        logic [31:0] fmt_len;
        logic [31:0] fmt_rate;
        logic [31:0] data_len;
        logic [31:0] junk_len;
        logic [15:0] fmt_code;
        logic [15:0] fmt_chans;
        logic [15:0] fmt_bits;
        int          n_data;
        int          cut;
        bit          tail;
        file_image.delete();
        if (fk == FK_NOISE)
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                push_tag(TAG_RIFF);
                push_le($urandom, 4);
                push_tag(TAG_WAVE);
            end
            repeat ($urandom_range(1, 20)) file_image = {file_image, pick_byte()};
            return;
        end

        fmt_len   = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(17, 19)) : 32'd16;
        fmt_rate  = ($urandom_range(0, 7) == 0) ? 32'($urandom) : cfg_rate;
        fmt_code  = 16'd1;
        fmt_chans = 16'd1;
        fmt_bits  = 16'd16;
        n_data    = $urandom_range(1, 2);
        case (fk)
            FK_GOOD:       fmt_rate = cfg_rate;
            FK_SHORT_FMT:  fmt_len = $urandom_range(0, 15);
            FK_BAD_CODE:   fmt_code = other_than(16'd1);
            FK_BAD_CHANS:  fmt_chans = other_than(16'd1);
            FK_BAD_BITS:   fmt_bits = other_than(16'd16);
            FK_WRONG_RATE: fmt_rate = cfg_rate ^ (32'd1 << $urandom_range(0, 31));
            default: ;
        endcase

        push_tag(TAG_RIFF);
        push_le($urandom, 4);
        if (fk == FK_BAD_WAVE)
            push_tag(TAG_WAVE ^ (32'd1 << $urandom_range(0, 31)));
        else
            push_tag(TAG_WAVE);

        if ($urandom_range(0, 2) == 0)
        begin
            junk_len = $urandom_range(0, 9);
            push_tag(($urandom_range(0, 1) == 1) ? TAG_LIST : 32'($urandom));
            push_le(junk_len, 4);
            repeat (junk_len) file_image = {file_image, 8'($urandom)};
            if (junk_len[0])
                file_image = {file_image, 8'($urandom)};
        end

        if (fk != FK_NO_FMT)
        begin
            push_tag(TAG_FMT);
            push_le(fmt_len, 4);
            if (fmt_len >= FMT_MIN_LEN)
            begin
                push_le(fmt_code, 2);
                push_le(fmt_chans, 2);
                push_le(fmt_rate, 4);
                push_le($urandom, 4);
                push_le($urandom, 2);
                push_le(fmt_bits, 2);
                repeat (fmt_len - FMT_MIN_LEN) file_image = {file_image, 8'($urandom)};
                if (fmt_len[0])
                    file_image = {file_image, 8'($urandom)};
            end
            else
                repeat ($urandom_range(0, 8)) file_image = {file_image, pick_byte()};
        end

        for (int i = 0; i < n_data; i++)
        begin
            tail = (i == n_data - 1);
            data_len = $urandom_range(0, 13);
            if (fk == FK_NO_SAMPLES && tail)
                data_len = $urandom_range(0, 1);
            if (fk == FK_LONG_DATA && tail)
                data_len = $urandom | 32'h100;
            push_tag(TAG_DATA);
            push_le(data_len, 4);
            if (fk == FK_LONG_DATA && tail)
                repeat ($urandom_range(0, 15)) file_image = {file_image, pick_byte()};
            else
            begin
                repeat (data_len) file_image = {file_image, pick_byte()};
                if (data_len[0])
                    file_image = {file_image, 8'($urandom)};
            end
        end

        if (fk == FK_CUT)
        begin
            cut = $urandom_range(1, file_image.size() - 1);
            while (file_image.size() > cut)
                void'(file_image.pop_back());
        end
    endfunction

    task automatic send_file();
        foreach (file_image[i])
            send_byte(file_image[i], i == file_image.size() - 1, 1'b0, wpp_pkg::ST_OK);
    endtask

    initial
    begin
        int         files_built;
        file_kind_t fk;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        in_data     = '0;
        row_typed   = 1'b0;
        row_status  = wpp_pkg::ST_OK;
        idling_on   = 1'b1;
        cfg_rate    = 32'd16000;
        files_built = 0;
        restart_file();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++)
            send_byte(DIRECTED[r].file_byte, DIRECTED[r].end_of_file, DIRECTED[r].typed,
                      DIRECTED[r].status);

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg > 0)
                set_required_rate((seg == 3) ? 32'($urandom) : RATE_PLAN[seg]);
            idling_on = (seg != 2 && seg != SEGMENTS - 1);
            while (bytes_sent < DIRECTED_ROWS + (seg + 1) * RANDOM_ITEMS / SEGMENTS)
            begin
                if (files_built <= int'(FK_NOISE))
                    fk = file_kind_t'(files_built);
                else if ($urandom_range(0, 2) == 0)
                    fk = FK_GOOD;
                else
                    fk = file_kind_t'($urandom_range(0, int'(FK_NOISE)));
                build_file(fk);
                send_file();
                files_built++;
                if ($urandom_range(0, 5) == 0)
                    wait_results_done();
            end
        end

        wait_results_done();
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/wpp_pkg.sv
hw/rtl/wpp_front.sv
hw/rtl/wpp_queue.sv
hw/rtl/wpp_back.sv
hw/rtl/wav_pcm16_mono_parser_core.sv
hw/rtl/wpp_checker.sv
sim/wav_pcm16_mono_parser_core_test.sv
